// File: design/spb_pkg.sv
package spb_pkg;

	typedef enum logic [1:0] {
		MODE_OFF      = 2'd0,
		MODE_ON       = 2'd1,
		MODE_BOOTING  = 2'd2,
		MODE_SHUTDOWN = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ACT_NONE     = 2'd0,
		ACT_DEBOUNCE = 2'd1,
		ACT_LONG     = 2'd2
	} action_t;

	localparam int DELAY_BITS = 16;

	// register map of the config port
	localparam logic REG_DEBOUNCE   = 1'b0;
	localparam logic REG_LONG_PRESS = 1'b1;

	localparam logic [DELAY_BITS-1:0] DEBOUNCE_RESET   = 16'd500;
	localparam logic [DELAY_BITS-1:0] LONG_PRESS_RESET = 16'd4500;

	// timer request from the control logic; load wins over clear
	typedef struct packed {
		logic                  load;
		logic                  clear;
		action_t               action;
		logic [DELAY_BITS-1:0] delay;
	} timer_cmd_t;

	typedef struct packed {
		logic debounce_done;
		logic long_done;
	} timer_fire_t;

	typedef struct packed {
		logic  atx;
		logic  led;
		logic  shutdown;
		mode_t mode;
	} status_t;

endpackage

// File: design/spb_timer.sv
module spb_timer #(
	parameter int TICK_COUNT_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  spb_pkg::timer_cmd_t cmd,
	output spb_pkg::timer_fire_t fire
);

	localparam int DW = (TICK_COUNT_BITS > spb_pkg::DELAY_BITS) ?
		TICK_COUNT_BITS : spb_pkg::DELAY_BITS;
	localparam logic [TICK_COUNT_BITS-1:0] CNT_ONE = TICK_COUNT_BITS'(1);

	logic [TICK_COUNT_BITS-1:0] count_q;
	spb_pkg::action_t           pending_q;

	logic [DW-1:0]              delay_ext;
	logic [DW-1:0]              delay_sat;
	logic                       expire;

	// zero loads as one, anything above the counter range saturates
	always_comb begin
		delay_ext = DW'(cmd.delay);
		delay_sat = delay_ext;
		if (delay_ext == '0)
			delay_sat = DW'(1);
		else if (delay_ext > DW'({TICK_COUNT_BITS{1'b1}}))
			delay_sat = DW'({TICK_COUNT_BITS{1'b1}});
	end

	assign expire = (pending_q != spb_pkg::ACT_NONE) && (count_q == CNT_ONE);
	assign fire.debounce_done = expire && (pending_q == spb_pkg::ACT_DEBOUNCE);
	assign fire.long_done     = expire && (pending_q == spb_pkg::ACT_LONG);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			pending_q <= spb_pkg::ACT_NONE;
		end else if (advance) begin
			if (cmd.load) begin
				count_q   <= delay_sat[TICK_COUNT_BITS-1:0];
				pending_q <= cmd.action;
			end else if (cmd.clear) begin
				count_q   <= '0;
				pending_q <= spb_pkg::ACT_NONE;
			end else if (pending_q != spb_pkg::ACT_NONE) begin
				count_q <= count_q - CNT_ONE;
				if (expire)
					pending_q <= spb_pkg::ACT_NONE;
			end
		end
	end

	a_pending_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != spb_pkg::ACT_NONE |-> count_q != '0)
		else $error("timer pending with zero count");

	a_fire_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({fire.debounce_done, fire.long_done}))
		else $error("both timer actions fired");

	a_load_takes: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cmd.load |=> pending_q == $past(cmd.action))
		else $error("timer load lost");

endmodule

// File: design/spb_ctrl.sv
module spb_ctrl (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   advance,
	input  logic                                   button,
	input  logic                                   host,
	input  logic [spb_pkg::DELAY_BITS-1:0]         debounce_ticks,
	input  logic [spb_pkg::DELAY_BITS-1:0]         long_press_ticks,
	input  spb_pkg::timer_fire_t                   fire,
	output spb_pkg::timer_cmd_t                    cmd,
	output spb_pkg::status_t                       status
);

	typedef enum logic [2:0] {
		EV_NONE,
		EV_PRESS,
		EV_RELEASE,
		EV_HOST_ON,
		EV_HOST_OFF
	} ev_t;

	spb_pkg::status_t status_q;
	logic             armed_q;
	logic             button_hist_q;
	logic             host_hist_q;

	spb_pkg::status_t status_d;
	logic             armed_d;
	ev_t              ev;

	// host edge outranks a button edge in the same beat
	always_comb begin
		ev = EV_NONE;
		if (host != host_hist_q)
			ev = host ? EV_HOST_ON : EV_HOST_OFF;
		else if (button != button_hist_q)
			ev = button ? EV_RELEASE : EV_PRESS;
	end

	always_comb begin
		status_d   = status_q;
		armed_d    = armed_q;
		cmd.load   = 1'b0;
		cmd.clear  = 1'b0;
		cmd.action = spb_pkg::ACT_NONE;
		cmd.delay  = long_press_ticks;

		// timer expiry first, then the edge event
		if (fire.debounce_done) begin
			if (status_q.mode != spb_pkg::MODE_OFF) begin
				armed_d    = 1'b1;
				cmd.load   = 1'b1;
				cmd.action = spb_pkg::ACT_LONG;
			end else begin
				armed_d       = 1'b0;
				status_d.mode = spb_pkg::MODE_BOOTING;
				status_d.led  = 1'b1;
				status_d.atx  = 1'b1;
			end
		end
		if (fire.long_done) begin
			armed_d  = 1'b0;
			status_d = '{atx: 1'b0, led: 1'b0, shutdown: 1'b0, mode: spb_pkg::MODE_OFF};
		end

		unique case (ev)
			EV_PRESS: begin
				armed_d    = 1'b0;
				cmd.load   = 1'b1;
				cmd.action = spb_pkg::ACT_DEBOUNCE;
				cmd.delay  = debounce_ticks;
			end
			EV_RELEASE: begin
				cmd.load  = 1'b0;
				cmd.clear = 1'b1;
				if (armed_d && status_d.mode != spb_pkg::MODE_OFF) begin
					status_d.mode     = spb_pkg::MODE_SHUTDOWN;
					status_d.shutdown = 1'b1;
				end
				armed_d = 1'b0;
			end
			EV_HOST_ON: begin
				status_d.mode = spb_pkg::MODE_ON;
				status_d.led  = 1'b1;
			end
			EV_HOST_OFF: begin
				status_d = '{atx: 1'b0, led: 1'b0, shutdown: 1'b0,
					mode: spb_pkg::MODE_OFF};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q      <= '{atx: 1'b0, led: 1'b0, shutdown: 1'b0,
				mode: spb_pkg::MODE_OFF};
			armed_q       <= 1'b0;
			button_hist_q <= 1'b1;
			host_hist_q   <= 1'b0;
		end else if (advance) begin
			status_q      <= status_d;
			armed_q       <= armed_d;
			button_hist_q <= button;
			host_hist_q   <= host;
		end
	end

	assign status = status_q;

endmodule

// File: design/soft_power_button_controller_core.sv
// Soft power button controller with long-press forced off.
// Input channel (in_valid/in_ready): one beat per timer tick, carrying the
// sampled button level (0 pressed) and the host running level.
// Output channel (out_valid/out_ready): exactly one beat per input beat with
// the supply, LED and shutdown drives and the power state after that tick.
// Config port: cfg_wr_en with cfg_index 0 writes the debounce delay, index 1
// the long press delay; write only while no tick is in flight.
// A tick lands in the input register and is evaluated into the state/result
// registers once no result waits on out_ready, which raises out_valid.
// Throughput: one tick per cycle while out_ready stays high; the limit is
// the single state update stage.
// Stall: while a result waits on out_ready, one more tick is held in the
// input register and in_ready drops until the result is taken.
// Reset: power off, LED off, no timer pending, button history released,
// host history off, delays back to 500 and 4500 ticks.
module soft_power_button_controller_core #(
	parameter int TICK_COUNT_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   button_level,
	input  logic                                   host_running_level,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic                                   atx_power_on,
	output logic                                   power_led_on,
	output logic                                   shutdown_request,
	output logic [1:0]                             power_state,
	input  logic                                   cfg_wr_en,
	input  logic                                   cfg_index,
	input  logic [spb_pkg::DELAY_BITS-1:0]         cfg_data
);

	logic                          valid_s1;
	logic                          button_s1;
	logic                          host_s1;
	logic                          out_valid_q;
	logic [spb_pkg::DELAY_BITS-1:0] debounce_q;
	logic [spb_pkg::DELAY_BITS-1:0] long_press_q;

	logic                          advance;
	spb_pkg::timer_cmd_t           cmd;
	spb_pkg::timer_fire_t          fire;
	spb_pkg::status_t              status;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			button_s1 <= button_level;
			host_s1   <= host_running_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= spb_pkg::DEBOUNCE_RESET;
			long_press_q <= spb_pkg::LONG_PRESS_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				spb_pkg::REG_DEBOUNCE:   debounce_q   <= cfg_data;
				spb_pkg::REG_LONG_PRESS: long_press_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	spb_timer #(
		.TICK_COUNT_BITS(TICK_COUNT_BITS)
	) u_timer (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cmd     (cmd),
		.fire    (fire)
	);

	spb_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.advance          (advance),
		.button           (button_s1),
		.host             (host_s1),
		.debounce_ticks   (debounce_q),
		.long_press_ticks (long_press_q),
		.fire             (fire),
		.cmd              (cmd),
		.status           (status)
	);

	// state registers double as the result register: they only move on advance
	assign out_valid        = out_valid_q;
	assign atx_power_on     = status.atx;
	assign power_led_on     = status.led;
	assign shutdown_request = status.shutdown;
	assign power_state      = status.mode;

	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("evaluated beat produced no result");

	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> $stable(status))
		else $error("state moved while result stalled");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int STALL_LEN      = 300;

	// directed tick sequence, first tick in the MSB
	localparam logic [23:0] DIR_BTN  = 24'b0011_0011_0001_0000_1101_1111;
	localparam logic [23:0] DIR_HOST = 24'b0001_1110_0011_1111_1001_1000;

	typedef struct packed {
		logic btn;
		logic host;
	} tick_t;

	logic                           clk                = 1'b0;
	logic                           arst_n;
	logic                           in_valid           = 1'b0;
	logic                           in_ready;
	logic                           button_level       = 1'b1;
	logic                           host_running_level = 1'b0;
	logic                           out_valid;
	logic                           out_ready          = 1'b0;
	logic                           atx_power_on;
	logic                           power_led_on;
	logic                           shutdown_request;
	logic [1:0]                     power_state;
	logic                           cfg_wr_en;
	logic                           cfg_index;
	logic [spb_pkg::DELAY_BITS-1:0] cfg_data;

	soft_power_button_controller_core i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.button_level      (button_level),
		.host_running_level(host_running_level),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.atx_power_on      (atx_power_on),
		.power_led_on      (power_led_on),
		.shutdown_request  (shutdown_request),
		.power_state       (power_state),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	// tick queue and expected status store
	tick_t            tick_q[$];
	spb_pkg::status_t status_q[$];
	int               items_left = 0;
	int               err_cnt    = 0;
	int               idle_cnt   = 0;
	logic             in_taken   = 1'b0;
	logic             gen_btn    = 1'b1;
	logic             gen_host   = 1'b0;

	// sender / receiver idling
	int               tx_gap    = 0;
	bit               tx_calm   = 1'b0;
	int               rx_hold   = 0;
	bit               rx_calm   = 1'b0;
	bit               long_hold = 1'b0;
	tick_t            tx_item;
	spb_pkg::status_t want;

	// controller state as the checker sees it
	logic [spb_pkg::DELAY_BITS-1:0] debounce_cfg = spb_pkg::DEBOUNCE_RESET;
	logic [spb_pkg::DELAY_BITS-1:0] long_cfg     = spb_pkg::LONG_PRESS_RESET;
	spb_pkg::mode_t                 pwr_mode     = spb_pkg::MODE_OFF;
	spb_pkg::action_t               timer_act    = spb_pkg::ACT_NONE;
	logic [spb_pkg::DELAY_BITS-1:0] ticks_left   = '0;
	logic                           long_armed   = 1'b0;
	logic                           btn_seen     = 1'b1;
	logic                           host_seen    = 1'b0;
	logic                           drv_atx      = 1'b0;
	logic                           drv_led      = 1'b0;
	logic                           drv_sd       = 1'b0;

	always #5 clk = ~clk;

	function automatic void start_timer(input spb_pkg::action_t act,
		input logic [spb_pkg::DELAY_BITS-1:0] dly);
		ticks_left = (dly == '0) ? spb_pkg::DELAY_BITS'(1) : dly;
		timer_act  = act;
	endfunction

	function automatic void drop_power();
		pwr_mode = spb_pkg::MODE_OFF;
		drv_atx  = 1'b0;
		drv_led  = 1'b0;
		drv_sd   = 1'b0;
	endfunction

	function automatic spb_pkg::status_t next_status(input logic btn, input logic host);
		logic             press_ev, let_go_ev, rise_ev, fall_ev;
		spb_pkg::action_t fired;
		spb_pkg::status_t s;
		rise_ev   = (host != host_seen) && host;
		fall_ev   = (host != host_seen) && !host;
		// a host edge hides a button edge in the same tick
		press_ev  = (host == host_seen) && (btn != btn_seen) && !btn;
		let_go_ev = (host == host_seen) && (btn != btn_seen) && btn;
		btn_seen  = btn;
		host_seen = host;

		if (timer_act != spb_pkg::ACT_NONE) begin
			ticks_left = ticks_left - 1'b1;
			if (ticks_left == '0) begin
				fired     = timer_act;
				timer_act = spb_pkg::ACT_NONE;
				if (fired == spb_pkg::ACT_DEBOUNCE) begin
					if (pwr_mode != spb_pkg::MODE_OFF) begin
						long_armed = 1'b1;
						start_timer(spb_pkg::ACT_LONG, long_cfg);
					end else begin
						long_armed = 1'b0;
						pwr_mode   = spb_pkg::MODE_BOOTING;
						drv_led    = 1'b1;
						drv_atx    = 1'b1;
					end
				end else begin
					long_armed = 1'b0;
					drop_power();
				end
			end
		end

		if (rise_ev) begin
			pwr_mode = spb_pkg::MODE_ON;
			drv_led  = 1'b1;
		end else if (fall_ev) begin
			drop_power();
		end else if (press_ev) begin
			long_armed = 1'b0;
			start_timer(spb_pkg::ACT_DEBOUNCE, debounce_cfg);
		end else if (let_go_ev) begin
			timer_act  = spb_pkg::ACT_NONE;
			ticks_left = '0;
			if (long_armed && pwr_mode != spb_pkg::MODE_OFF) begin
				pwr_mode = spb_pkg::MODE_SHUTDOWN;
				drv_sd   = 1'b1;
			end
			long_armed = 1'b0;
		end

		s.atx      = drv_atx;
		s.led      = drv_led;
		s.shutdown = drv_sd;
		s.mode     = pwr_mode;
		return s;
	endfunction

	task automatic report_mismatch(input string msg);
		err_cnt++;
		if (err_cnt <= 40)
			$display("ERROR at %0t: %s", $time, msg);
	endtask

	function automatic int idle_len(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 4)
			return $urandom_range(10, 40);
		if (r < 25)
			return $urandom_range(1, 3);
		return 0;
	endfunction

	// driver
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if ($urandom_range(0, 199) == 0)
				tx_calm = !tx_calm;
			if (tx_gap > 0) begin
				tx_gap--;
				in_valid <= 1'b0;
			end else if (tick_q.size() != 0) begin
				tx_item = tick_q.pop_front();
				in_valid <= 1'b1;
				button_level <= tx_item.btn;
				host_running_level <= tx_item.host;
				tx_gap = idle_len(tx_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0)
			rx_calm = !rx_calm;
		if (long_hold) begin
			rx_hold   = STALL_LEN;
			long_hold = 1'b0;
		end
		if (rx_hold > 0) begin
			rx_hold--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			rx_hold = idle_len(rx_calm);
		end
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en) begin
				case (cfg_index)
					spb_pkg::REG_DEBOUNCE:   debounce_cfg = cfg_data;
					spb_pkg::REG_LONG_PRESS: long_cfg     = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				status_q.push_back(next_status(button_level, host_running_level));
				items_left--;
			end
			if (out_valid && out_ready) begin
				if (status_q.size() == 0) begin
					report_mismatch("result beat with nothing expected");
				end else begin
					want = status_q.pop_front();
					if (atx_power_on !== want.atx)
						report_mismatch($sformatf("atx_power_on %b, want %b",
							atx_power_on, want.atx));
					if (power_led_on !== want.led)
						report_mismatch($sformatf("power_led_on %b, want %b",
							power_led_on, want.led));
					if (shutdown_request !== want.shutdown)
						report_mismatch($sformatf("shutdown_request %b, want %b",
							shutdown_request, want.shutdown));
					if (power_state !== want.mode)
						report_mismatch($sformatf("power_state %0d, want %0d",
							power_state, want.mode));
				end
			end
		end
		in_taken <= in_valid && in_ready;
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt == WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic hold_levels(input logic btn, input logic host, input int n);
		repeat (n) tick_q.push_back('{btn, host});
		items_left += n;
		gen_btn  = btn;
		gen_host = host;
	endtask

	task automatic write_reg(input logic idx, input logic [spb_pkg::DELAY_BITS-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// wait until every tick has come back, then let the pipeline go quiet
	task automatic settle();
		do
			@(negedge clk);
		while (items_left != 0 || status_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// mostly press/hold/release with hold lengths around the timer thresholds
	task automatic random_ticks(input int d, input int l, input int n);
		int left, r, hold;
		left = n;
		while (left > 0) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				if (!gen_btn)
					hold_levels(1'b1, gen_host, 1);
				case ($urandom_range(0, 3))
					0: hold = $urandom_range(1, d + 1);
					1: hold = d + $urandom_range(0, 2);
					2: hold = d + l + $urandom_range(0, 2) - 1;
					default: hold = $urandom_range(1, d + l + 3);
				endcase
				hold_levels(1'b0, gen_host, hold);
				hold_levels(1'b1, gen_host, $urandom_range(1, 4));
				left -= hold + 2;
			end else if (r < 78) begin
				hold_levels(gen_btn, !gen_host, $urandom_range(1, 4));
				left -= 2;
			end else if (r < 86) begin
				hold_levels(!gen_btn, !gen_host, $urandom_range(1, 3));
				left -= 2;
			end else begin
				hold = $urandom_range(1, 6);
				repeat (hold)
					hold_levels(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1);
				left -= hold;
			end
		end
	endtask

	initial begin
		int d, l;
		arst_n    = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = spb_pkg::REG_DEBOUNCE;
		cfg_data  = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// reset delays: nothing fires, edges only
		hold_levels(1'b1, 1'b0, 1);
		hold_levels(1'b0, 1'b1, 1);
		hold_levels(1'b1, 1'b0, 1);
		hold_levels(1'b0, 1'b0, 1);
		hold_levels(1'b1, 1'b0, 1);
		settle();

		// zero debounce loads as one tick
		write_reg(spb_pkg::REG_DEBOUNCE, '0);
		write_reg(spb_pkg::REG_LONG_PRESS, spb_pkg::DELAY_BITS'(2));
		for (int i = 23; i >= 0; i--)
			hold_levels(DIR_BTN[i], DIR_HOST[i], 1);
		settle();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin d = 1; l = 1; end
				1: begin d = 2; l = 3; end
				2: begin d = 8; l = 1; end
				default: begin
					d = $urandom_range(1, 8);
					l = $urandom_range(1, 8);
				end
			endcase
			write_reg(spb_pkg::REG_DEBOUNCE, spb_pkg::DELAY_BITS'(d));
			write_reg(spb_pkg::REG_LONG_PRESS, spb_pkg::DELAY_BITS'(l));
			random_ticks(d, l, 250);
			if (p == 2)
				long_hold = 1'b1;
			settle();
		end

		// full-range delays: a short press never reaches the debounce
		write_reg(spb_pkg::REG_DEBOUNCE, '1);
		write_reg(spb_pkg::REG_LONG_PRESS, '1);
		hold_levels(1'b1, 1'b0, 2);
		hold_levels(1'b0, 1'b0, 8);
		hold_levels(1'b1, 1'b0, 2);
		hold_levels(1'b1, 1'b1, 2);
		settle();

		if (err_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
